/* rtl/u8dv_pkg.sv */
// Shared types, status codes and lookup functions for the UTF-8 decoder.
package u8dv_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_ILLSTART = 3'd2,
    ST_NOTCONT  = 3'd3,
    ST_OVERLONG = 3'd4
  } status_t;

  localparam int unsigned CP_W     = 31;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned SEQ_W    = 3;
  localparam logic [SEQ_W-1:0] SEQ_ILLEGAL = 3'd0;

  // Sequence length from the start byte; SEQ_ILLEGAL where no sequence can start.
  function automatic logic [SEQ_W-1:0] seq_len(input logic [7:0] b);
    logic [SEQ_W-1:0] len;
    case (b) inside
      [8'h00:8'h7F]: len = 3'd1;
      [8'hC0:8'hDF]: len = 3'd2;
      [8'hE0:8'hEF]: len = 3'd3;
      [8'hF0:8'hF7]: len = 3'd4;
      [8'hF8:8'hFB]: len = 3'd5;
      [8'hFC:8'hFD]: len = 3'd6;
      default:       len = SEQ_ILLEGAL;
    endcase
    return len;
  endfunction

  // Smallest value that a sequence of the given length may carry.
  function automatic logic [CP_W-1:0] min_value(input logic [SEQ_W-1:0] len);
    logic [CP_W-1:0] v;
    case (len)
      3'd2:    v = 31'h0000_0080;
      3'd3:    v = 31'h0000_0800;
      3'd4:    v = 31'h0001_0000;
      3'd5:    v = 31'h0020_0000;
      3'd6:    v = 31'h0400_0000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/utf8_decode_validate_top.sv */
// UTF-8 decoder and validator, one byte per beat, 1 to 6 byte sequences.
// Takes one byte per cycle when not stalled; each result passes through the byte register, then
// the result register. All decoding, the sequence state and the counters update in the logic
// between the byte register and the result register, so throughput is set by that one stage and
// is one byte per cycle while out_stall does not hold the result register. A full result register
// may be held by out_stall while the byte register keeps the next byte.
// No clearing pass after reset; per-string state clears on the last byte of each string.
module utf8_decode_validate_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_char_valid,
  output logic [30:0] out_code_point,
  output logic        out_end_of_string,
  output logic [2:0]  out_status,
  output logic [15:0] out_char_count
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int unsigned CP_W  = u8dv_pkg::CP_W;
  localparam int unsigned SEQ_W = u8dv_pkg::SEQ_W;

  // configuration
  logic [15:0] emit_limit_r;

  // byte register
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;

  // string state
  logic [SEQ_W-1:0]       rem_r, rem_nxt;
  logic [SEQ_W-1:0]       seq_len_r, seq_len_nxt;
  logic [CP_W-1:0]        acc_r, acc_nxt;
  logic                   pend_r, pend_nxt;
  u8dv_pkg::status_t      err_r, err_nxt;
  logic [COUNT_WIDTH-1:0] dec_cnt_r, dec_cnt_nxt;
  logic [COUNT_WIDTH-1:0] emit_cnt_r, emit_cnt_nxt;

  // result register
  logic              out_valid_r;
  logic              char_valid_r, char_valid_nxt;
  logic [CP_W-1:0]   code_point_r, code_point_nxt;
  logic              eos_r;
  u8dv_pkg::status_t status_r;
  logic [15:0]       char_count_r, char_count_nxt;

  logic             out_adv;
  logic             s1_adv;
  logic             step;
  logic [SEQ_W-1:0] want;
  logic             fin;
  logic [CMP_W-1:0] dec_ext;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_stall = !s1_adv;
  assign step     = s1_valid_r && out_adv;
  assign want     = u8dv_pkg::seq_len(s1_data_r);

  always_comb begin
    rem_nxt        = rem_r;
    seq_len_nxt    = seq_len_r;
    acc_nxt        = acc_r;
    pend_nxt       = pend_r;
    err_nxt        = err_r;
    dec_cnt_nxt    = dec_cnt_r;
    emit_cnt_nxt   = emit_cnt_r;
    char_valid_nxt = 1'b0;
    code_point_nxt = '0;
    fin            = 1'b0;

    if (err_r == u8dv_pkg::ST_OK) begin
      if (rem_r == '0) begin
        if (want == u8dv_pkg::SEQ_ILLEGAL) begin
          err_nxt = u8dv_pkg::ST_ILLSTART;
        end else begin
          seq_len_nxt = want;
          pend_nxt    = 1'b0;
          acc_nxt     = CP_W'(s1_data_r & (8'hFF >> want));
          rem_nxt     = want - 3'd1;
          if (rem_nxt == '0) begin
            fin = 1'b1;
          end else if (s1_last_r) begin
            err_nxt = u8dv_pkg::ST_TRUNC;
          end
        end
      end else begin
        if (!pend_r) begin
          if (s1_data_r[7:6] != 2'b10) begin
            pend_nxt = 1'b1;
          end else begin
            acc_nxt = {acc_r[CP_W-7:0], s1_data_r[5:0]};
          end
        end
        rem_nxt = rem_r - 3'd1;
        if (rem_nxt == '0) begin
          fin = 1'b1;
        end else if (s1_last_r) begin
          err_nxt = u8dv_pkg::ST_TRUNC;
        end
      end
    end

    // finish the sequence: check, count, emit
    if (fin) begin
      if (pend_nxt) begin
        err_nxt = u8dv_pkg::ST_NOTCONT;
      end else if (acc_nxt < u8dv_pkg::min_value(seq_len_nxt)) begin
        err_nxt = u8dv_pkg::ST_OVERLONG;
      end else begin
        if (dec_cnt_r != '1) begin
          dec_cnt_nxt = dec_cnt_r + 1'b1;
        end
        if (CMP_W'(emit_cnt_r) < CMP_W'(emit_limit_r)) begin
          if (emit_cnt_r != '1) begin
            emit_cnt_nxt = emit_cnt_r + 1'b1;
          end
          char_valid_nxt = 1'b1;
          code_point_nxt = acc_nxt;
        end
      end
    end
  end

  assign dec_ext        = CMP_W'(dec_cnt_nxt);
  assign char_count_nxt = dec_ext[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_limit_r <= 16'hFFFF;
    end else if (cfg_we) begin
      emit_limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r      <= '0;
      seq_len_r  <= '0;
      acc_r      <= '0;
      pend_r     <= 1'b0;
      err_r      <= u8dv_pkg::ST_OK;
      dec_cnt_r  <= '0;
      emit_cnt_r <= '0;
    end else if (step) begin
      if (s1_last_r) begin
        // drop all string state after the last byte
        rem_r      <= '0;
        seq_len_r  <= '0;
        acc_r      <= '0;
        pend_r     <= 1'b0;
        err_r      <= u8dv_pkg::ST_OK;
        dec_cnt_r  <= '0;
        emit_cnt_r <= '0;
      end else begin
        rem_r      <= rem_nxt;
        seq_len_r  <= seq_len_nxt;
        acc_r      <= acc_nxt;
        pend_r     <= pend_nxt;
        err_r      <= err_nxt;
        dec_cnt_r  <= dec_cnt_nxt;
        emit_cnt_r <= emit_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      char_valid_r <= char_valid_nxt;
      code_point_r <= code_point_nxt;
      eos_r        <= s1_last_r;
      status_r     <= err_nxt;
      char_count_r <= char_count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_char_valid    = char_valid_r;
  assign out_code_point    = code_point_r;
  assign out_end_of_string = eos_r;
  assign out_status        = status_r;
  assign out_char_count    = char_count_r;

endmodule

/* rtl/u8dv_checker.sv */
// Port-level checker for the UTF-8 decoder, bound to the top level.
module u8dv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_char_valid,
  input logic [30:0] out_code_point,
  input logic        out_end_of_string,
  input logic [2:0]  out_status,
  input logic [15:0] out_char_count
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_point)
      && $stable(out_char_valid) && $stable(out_status) && $stable(out_char_count)
      && $stable(out_end_of_string))
    else $error("stalled result beat changed");

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an emitted code point never comes with an error status
  a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_valid |-> out_status == 3'(u8dv_pkg::ST_OK))
    else $error("code point emitted with error status");

  // code point field is zero when nothing is emitted
  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_code_point == 31'd0)
    else $error("code point nonzero without char_valid");

endmodule

bind utf8_decode_validate_top u8dv_checker u_u8dv_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for the streaming UTF-8 decoder and validator.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    logic                      char_valid;
    logic [u8dv_pkg::CP_W-1:0] code_point;
    logic                      end_of_string;
    u8dv_pkg::status_t         status;
    logic [15:0]               char_count;
  } decode_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_char_valid;
  logic [30:0] out_code_point;
  logic        out_end_of_string;
  logic [2:0]  out_status;
  logic [15:0] out_char_count;

  // Decoder state mirrored from the accepted bytes.
  logic [2:0]                   rem_conts = '0;
  logic [2:0]                   cur_len = '0;
  logic [u8dv_pkg::CP_W-1:0]    partial_cp = '0;
  logic                         cont_broken = 1'b0;
  u8dv_pkg::status_t            str_status = u8dv_pkg::ST_OK;
  logic [15:0]                  char_total = '0;
  logic [15:0]                  chars_out = '0;
  logic [u8dv_pkg::LIMIT_W-1:0] emit_cap = 16'hFFFF;

  decode_result_t decoded_q[$];
  logic [7:0]     text_q[$];
  logic [7:0]     enc_q[$];

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  utf8_decode_validate_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char_valid    (out_char_valid),
    .out_code_point    (out_code_point),
    .out_end_of_string (out_end_of_string),
    .out_status        (out_status),
    .out_char_count    (out_char_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    if (!b[7]) return 3'd1;
    if (b[7:5] == 3'b110) return 3'd2;
    if (b[7:4] == 4'b1110) return 3'd3;
    if (b[7:3] == 5'b11110) return 3'd4;
    if (b[7:2] == 6'b111110) return 3'd5;
    if (b[7:1] == 7'b1111110) return 3'd6;
    return u8dv_pkg::SEQ_ILLEGAL;
  endfunction

  // Smallest value that is not an overlong form for a sequence of n bytes.
  function automatic logic [u8dv_pkg::CP_W-1:0] shortest_floor(input logic [2:0] n);
    case (n)
      3'd2:    return 31'h0000_0080;
      3'd3:    return 31'h0000_0800;
      3'd4:    return 31'h0001_0000;
      3'd5:    return 31'h0020_0000;
      3'd6:    return 31'h0400_0000;
      default: return '0;
    endcase
  endfunction

  function automatic void close_char(inout decode_result_t r);
    if (cont_broken) begin
      str_status = u8dv_pkg::ST_NOTCONT;
    end else if (partial_cp < shortest_floor(cur_len)) begin
      str_status = u8dv_pkg::ST_OVERLONG;
    end else begin
      if (char_total != 16'hFFFF) char_total++;
      if (chars_out < emit_cap) begin
        if (chars_out != 16'hFFFF) chars_out++;
        r.char_valid = 1'b1;
        r.code_point = partial_cp;
      end
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic is_last);
    decode_result_t r;
    logic [2:0] n;
    r = '0;
    r.end_of_string = is_last;
    if (str_status == u8dv_pkg::ST_OK) begin
      if (rem_conts == 3'd0) begin
        n = lead_length(b);
        if (n == u8dv_pkg::SEQ_ILLEGAL) begin
          str_status = u8dv_pkg::ST_ILLSTART;
        end else begin
          cur_len = n;
          cont_broken = 1'b0;
          partial_cp = 31'(b & (8'hFF >> n));
          rem_conts = n - 3'd1;
          if (rem_conts == 3'd0) close_char(r);
          else if (is_last) str_status = u8dv_pkg::ST_TRUNC;
        end
      end else begin
        // a bad continuation poisons the rest of the sequence
        if (!cont_broken) begin
          if (b[7:6] != 2'b10) cont_broken = 1'b1;
          else partial_cp = {partial_cp[24:0], b[5:0]};
        end
        rem_conts = rem_conts - 3'd1;
        if (rem_conts == 3'd0) close_char(r);
        else if (is_last) str_status = u8dv_pkg::ST_TRUNC;
      end
    end
    r.status = str_status;
    r.char_count = char_total;
    decoded_q.push_back(r);
    if (is_last) begin
      rem_conts = '0;
      cur_len = '0;
      partial_cp = '0;
      cont_broken = 1'b0;
      str_status = u8dv_pkg::ST_OK;
      char_total = '0;
      chars_out = '0;
    end
  endfunction

  function automatic void report_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endfunction

  function automatic void compare_result();
    decode_result_t want;
    if (decoded_q.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: result beat with none expected, code_point %0h status %0d",
                 $time, out_code_point, out_status);
    end else begin
      want = decoded_q.pop_front();
      if (out_char_valid !== want.char_valid)
        report_field("char_valid", 32'(want.char_valid), 32'(out_char_valid));
      if (out_code_point !== want.code_point)
        report_field("code_point", 32'(want.code_point), 32'(out_code_point));
      if (out_end_of_string !== want.end_of_string)
        report_field("end_of_string", 32'(want.end_of_string), 32'(out_end_of_string));
      if (out_status !== want.status)
        report_field("status", 32'(want.status), 32'(out_status));
      if (out_char_count !== want.char_count)
        report_field("char_count", 32'(want.char_count), 32'(out_char_count));
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) compare_result();
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    @(negedge clk);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_last_byte <= 1'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= is_last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_text();
    int unsigned i;
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // Drop valid and hold until every expected beat has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_emit_limit(input logic [15:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    emit_cap = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void encode_char(input int n, input logic [u8dv_pkg::CP_W-1:0] v);
    logic [7:0] lead_mask;
    int k;
    lead_mask = 8'hFF << (8 - n);
    if (n == 1) lead_mask = 8'h00;
    enc_q.delete();
    enc_q.push_back(lead_mask | 8'(v >> (6 * (n - 1))));
    for (k = n - 2; k >= 0; k--) enc_q.push_back(8'h80 | (8'(v >> (6 * k)) & 8'h3F));
  endfunction

  function automatic logic [u8dv_pkg::CP_W-1:0] pick_value(input int n, input bit overlong);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = 32'(shortest_floor(3'(n)));
    hi = (32'd1 << (n == 1 ? 7 : 5 * n + 1)) - 32'd1;
    if (overlong && n > 1) return 31'($urandom_range(lo - 32'd1, 0));
    case ($urandom_range(9))
      0:       return 31'(lo);
      1:       return 31'(hi);
      default: return 31'($urandom_range(hi, lo));
    endcase
  endfunction

  // Mostly clean text; the rest mixes in overlongs, stray bytes, broken and truncated sequences.
  task automatic build_text();
    int unsigned nchars;
    int unsigned roll;
    int unsigned keep;
    int unsigned i;
    int n;
    bit clean;
    bit stop;
    text_q.delete();
    clean = $urandom_range(99) < 60;
    nchars = $urandom_range(10, 1);
    stop = 1'b0;
    for (i = 0; i < nchars && !stop; i++) begin
      roll = clean ? 0 : $urandom_range(99);
      n = $urandom_range(6, 1);
      if (roll < 60) begin
        encode_char(n, pick_value(n, 1'b0));
      end else if (roll < 70) begin
        encode_char(n, pick_value(n, 1'b1));
      end else if (roll < 78) begin
        enc_q = '{8'($urandom)};
      end else if (roll < 86) begin
        encode_char(n, pick_value(n, 1'b0));
        if (n > 1)
          enc_q[$urandom_range(n - 1, 1)] =
            $urandom_range(1) ? 8'($urandom_range(8'h7F, 0)) : 8'($urandom_range(8'hFF, 8'hC0));
      end else if (roll < 93) begin
        encode_char(n, pick_value(n, 1'b0));
        if (n > 1) begin
          keep = $urandom_range(n - 1, 1);
          enc_q = enc_q[0:keep-1];
          stop = 1'b1;
        end
      end else begin
        enc_q = '{$urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                    : 8'($urandom_range(8'hFF, 8'hFE))};
      end
      text_q = {text_q, enc_q};
    end
  endtask

  task automatic run_random_texts(input int unsigned n_bytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      build_text();
      send_text();
    end
  endtask

  task automatic test_boundary_strings();
    send_gap_pct = 0;
    stall_pct = 0;
    text_q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF,
               8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
    send_text();
    text_q = '{8'hC0, 8'h80, 8'h41};   // overlong, then ignored tail
    send_text();
    text_q = '{8'hE2, 8'h41, 8'h82};   // bad continuation, sequence completes
    send_text();
    text_q = '{8'hE2, 8'h41};          // bad continuation cut off by end of string
    send_text();
    text_q = '{8'hC3};                 // multibyte lead on the last byte
    send_text();
    text_q = '{8'hFE};
    send_text();
    text_q = '{8'h80};
    send_text();
    text_q = '{8'hFF};
    send_text();
  endtask

  task automatic test_steady_stream();
    set_emit_limit(16'hFFFF);
    send_gap_pct = 0;
    stall_pct = 0;
    run_random_texts(150);
  endtask

  task automatic test_sender_gaps();
    set_emit_limit(16'd0);
    send_gap_pct = 74;
    stall_pct = 0;
    run_random_texts(150);
  endtask

  task automatic test_receiver_stalls();
    set_emit_limit(16'd1);
    send_gap_pct = 0;
    stall_pct = 74;
    run_random_texts(150);
  endtask

  task automatic test_both_idle();
    set_emit_limit(16'd3);
    send_gap_pct = 23;
    stall_pct = 23;
    run_random_texts(150);
  endtask

  task automatic test_random_limit();
    set_emit_limit(16'($urandom_range(12, 2)));
    send_gap_pct = 0;
    stall_pct = 0;
    run_random_texts(75);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_boundary_strings();
    test_steady_stream();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_random_limit();
    wait_idle();
    repeat (8) @(negedge clk);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
